>>> rtl/fpa_pkg.sv
// Package for the fixed-point ALU: operation codes, widths and shared types.
// No dependencies.
package fpa_pkg;

    localparam int DataWidth     = 32;
    localparam int FracBitsDflt  = 8;

    typedef enum logic [3:0] {
        OP_ADD  = 4'd0,
        OP_SUB  = 4'd1,
        OP_MUL  = 4'd2,
        OP_DIV  = 4'd3,
        OP_MIN  = 4'd4,
        OP_MAX  = 4'd5,
        OP_INC  = 4'd6,
        OP_DEC  = 4'd7,
        OP_I2F  = 4'd8,
        OP_F2I  = 4'd9
    } op_t;

    typedef struct packed {
        logic less;
        logic equal;
        logic greater;
    } cmp_t;

endpackage

>>> rtl/fpa_div.sv
// Pipelined unsigned restoring divider with rounding, one quotient bit per stage.
// Depends on fpa_pkg.
module fpa_div
    import fpa_pkg::*;
#(
    parameter int FRAC_BITS = FracBitsDflt
)
(
    input  logic                          clk,
    input  logic [DataWidth-1:0]          num_mag,
    input  logic [DataWidth-1:0]          den_mag,
    output logic [DataWidth+FRAC_BITS:0]  quot
);
    // quotient of (2n+d)/(2d); numerator up to DataWidth+FRAC_BITS+2 bits
    localparam int NW = DataWidth + FRAC_BITS + 2;
    localparam int DW = DataWidth + 1;

    logic [NW-1:0] num0;
    logic [DW-1:0] den0;

    logic [NW-1:0] num_reg [1:NW-1];
    logic [DW-1:0] den_reg [1:NW-1];
    logic [DW-1:0] rem_reg [1:NW-1];
    logic [NW-1:0] q_reg   [1:NW];

    assign num0 = ({{(NW-DataWidth){1'b0}}, num_mag} << (FRAC_BITS + 1))
                  + {{(NW-DataWidth){1'b0}}, den_mag};
    assign den0 = {den_mag, 1'b0};

    genvar s;
    generate
        for (s = 0; s < NW; s++)
        begin : g_stage
            logic [NW-1:0] num_in;
            logic [DW-1:0] den_in;
            logic [DW-1:0] rem_in;
            logic [NW-1:0] q_in;
            logic [DW:0]   trial;
            logic [DW:0]   diff;
            logic          fits;

            if (s == 0)
            begin : g_first
                assign num_in = num0;
                assign den_in = den0;
                assign rem_in = '0;
                assign q_in   = '0;
            end
            else
            begin : g_next
                assign num_in = num_reg[s];
                assign den_in = den_reg[s];
                assign rem_in = rem_reg[s];
                assign q_in   = q_reg[s];
            end

            assign trial = {rem_in, num_in[NW-1-s]};
            assign fits  = trial >= {1'b0, den_in};
            assign diff  = trial - {1'b0, den_in};

            always_ff @(posedge clk)
            begin
                q_reg[s+1] <= {q_in[NW-2:0], fits};
            end

            // the partial remainder stays below the divisor, so DW bits hold it
            if (s < NW - 1)
            begin : g_pass
                always_ff @(posedge clk)
                begin
                    num_reg[s+1] <= num_in;
                    den_reg[s+1] <= den_in;
                    rem_reg[s+1] <= fits ? diff[DW-1:0] : trial[DW-1:0];
                end
            end
        end
    endgenerate

    // quotient fits DataWidth+FRAC_BITS+1 bits since 2n+d < 2^(NW)
    assign quot = q_reg[NW][DataWidth+FRAC_BITS:0];
endmodule

>>> rtl/fixed_point_alu_core.sv
// Fixed-point ALU top level: operand decode, add, subtract, multiply, divide, min/max, inc/dec, conversions, saturate.
// Depends on fpa_pkg and fpa_div.
// Pipeline: the decode registers, a delay line as deep as the bit-per-stage divider,
// then the output registers that drive done; every mode travels the same depth.
// Throughput: one item per cycle; busy is always low, results cannot stall.
// Reset: rst_n clears the valid bits; payload registers are not reset.
module fixed_point_alu_core
    import fpa_pkg::*;
#(
    parameter int FRAC_BITS = FracBitsDflt
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic [3:0]                  mode,
    input  logic signed [DataWidth-1:0] operand_a,
    input  logic signed [DataWidth-1:0] operand_b,
    output logic                        done,
    output logic signed [DataWidth-1:0] result,
    output logic                        less,
    output logic                        equal,
    output logic                        greater,
    output logic                        overflow,
    output logic                        divide_by_zero
);
    localparam int NW    = DataWidth + FRAC_BITS + 2;
    localparam int DEPTH = NW;   // delay line length matching the divider
    localparam int QW    = DataWidth + FRAC_BITS + 1;
    localparam int EW    = 2 * DataWidth + 2;  // wide signed working value

    typedef struct packed {
        logic [3:0]                  mode;
        logic signed [DataWidth-1:0] a;
        logic signed [DataWidth-1:0] b;
        logic                        neg;
        logic                        dz;
        cmp_t                        cmp;
    } item_t;

    // never stalls: take an item every cycle
    assign busy = 1'b0;

    // stage 0: decode magnitudes, sign, zero-divisor and compare flags
    logic                 v0_reg;
    item_t                it0_reg;
    logic [DataWidth-1:0] ma0_reg, mb0_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v0_reg <= 1'b0;
        else
            v0_reg <= start;
    end

    always_ff @(posedge clk)
    begin
        it0_reg.mode        <= mode;
        it0_reg.a           <= operand_a;
        it0_reg.b           <= operand_b;
        it0_reg.neg         <= operand_a[DataWidth-1] ^ operand_b[DataWidth-1];
        it0_reg.dz          <= (operand_b == '0);
        it0_reg.cmp.less    <= operand_a < operand_b;
        it0_reg.cmp.equal   <= operand_a == operand_b;
        it0_reg.cmp.greater <= operand_a > operand_b;
        ma0_reg <= operand_a[DataWidth-1] ? DataWidth'(-operand_a) : operand_a;
        mb0_reg <= operand_b[DataWidth-1] ? DataWidth'(-operand_b) : operand_b;
    end

    // divider runs on every item; quotient used only for divide
    logic [QW-1:0] quot;
    fpa_div #(.FRAC_BITS(FRAC_BITS)) u_div (
        .clk      (clk),
        .num_mag  (ma0_reg),
        .den_mag  (mb0_reg),
        .quot     (quot)
    );

    // multiply in stage 1, round in stage 2, then hold in the delay line
    logic [2*DataWidth-1:0] prod1_reg;
    logic [2*DataWidth-1:0] mulr2_reg;

    always_ff @(posedge clk)
    begin
        prod1_reg <= ma0_reg * mb0_reg;
        mulr2_reg <= (prod1_reg + ((2*DataWidth)'(1) << (FRAC_BITS-1))) >> FRAC_BITS;
    end

    // delay lines for item fields and valid, align with the divider output
    item_t it_pipe_reg [DEPTH];
    logic  v_pipe_reg  [DEPTH];
    logic [2*DataWidth-1:0] mul_pipe_reg [2:DEPTH-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < DEPTH; i++)
                v_pipe_reg[i] <= 1'b0;
        end
        else
        begin
            v_pipe_reg[0] <= v0_reg;
            for (int i = 1; i < DEPTH; i++)
                v_pipe_reg[i] <= v_pipe_reg[i-1];
        end
    end

    always_ff @(posedge clk)
    begin
        it_pipe_reg[0] <= it0_reg;
        for (int i = 1; i < DEPTH; i++)
            it_pipe_reg[i] <= it_pipe_reg[i-1];
        // tap the rounded product from mulr2_reg into slot 2 of the delay line
        mul_pipe_reg[2] <= mulr2_reg;
        for (int i = 3; i < DEPTH; i++)
            mul_pipe_reg[i] <= mul_pipe_reg[i-1];
    end

    // final stage: select, sign and saturate
    item_t            itf;
    logic signed [EW-1:0] wide;
    logic signed [EW-1:0] ea, eb;
    logic             valid_mode;
    logic signed [DataWidth-1:0] res_next;
    logic             ovf_next;

    assign itf = it_pipe_reg[DEPTH-1];
    assign ea  = EW'(itf.a);
    assign eb  = EW'(itf.b);

    always_comb
    begin
        wide       = '0;
        valid_mode = 1'b1;
        case (itf.mode)
            OP_ADD: wide = ea + eb;
            OP_SUB: wide = ea - eb;
            OP_MUL:
            begin
                if (itf.neg)
                    wide = -$signed({2'b00, mul_pipe_reg[DEPTH-1]});
                else
                    wide = $signed({2'b00, mul_pipe_reg[DEPTH-1]});
            end
            OP_DIV:
            begin
                if (itf.dz)
                    wide = '0;
                else if (itf.neg)
                    wide = -$signed(EW'(quot));
                else
                    wide = $signed(EW'(quot));
            end
            OP_MIN: wide = itf.cmp.less ? ea : eb;
            OP_MAX: wide = itf.cmp.greater ? ea : eb;
            OP_INC: wide = ea + EW'(1);
            OP_DEC: wide = ea - EW'(1);
            OP_I2F: wide = ea <<< FRAC_BITS;
            OP_F2I: wide = ea >>> FRAC_BITS;
            default:
            begin
                wide       = '0;
                valid_mode = 1'b0;
            end
        endcase
        ovf_next = 1'b0;
        res_next = DataWidth'(wide);
        if (wide > EW'(signed'({1'b0, {(DataWidth-1){1'b1}}})))
        begin
            ovf_next = 1'b1;
            res_next = {1'b0, {(DataWidth-1){1'b1}}};
        end
        else if (wide < -EW'(signed'({1'b0, 1'b1, {(DataWidth-1){1'b0}}})))
        begin
            ovf_next = 1'b1;
            res_next = {1'b1, {(DataWidth-1){1'b0}}};
        end
    end

    logic done_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= v_pipe_reg[DEPTH-1];
    end

    logic signed [DataWidth-1:0] result_reg;
    logic                        ovf_reg, dz_reg;
    cmp_t                        cmp_reg;
    always_ff @(posedge clk)
    begin
        result_reg <= res_next;
        ovf_reg    <= ovf_next & valid_mode;
        dz_reg     <= (itf.mode == OP_DIV) && itf.dz;
        cmp_reg    <= itf.cmp;
    end

    assign done           = done_reg;
    assign result         = result_reg;
    assign less           = cmp_reg.less;
    assign equal          = cmp_reg.equal;
    assign greater        = cmp_reg.greater;
    assign overflow       = ovf_reg;
    assign divide_by_zero = dz_reg;

    // exactly one compare flag with each result
    a_cmp_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $onehot({less, equal, greater}))
        else $error("compare flags not one-hot");

    // divide by zero never comes with overflow and returns zero
    a_dz_clean: assert property (@(posedge clk) disable iff (!rst_n)
        done && divide_by_zero |-> !overflow && result == '0)
        else $error("divide by zero result not clean");

endmodule

>>> tb/tb_fixed_point_alu_core.sv
// Testbench for fixed_point_alu_core: directed and random ALU items, results checked
// in order against a behavioral predictor of the fixed-point arithmetic.
// Depends on fpa_pkg and the RTL of fixed_point_alu_core.
module tb_fixed_point_alu_core;
    import fpa_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int FracBits  = FracBitsDflt;
    localparam int Latency   = DataWidth + FracBits + 3;
    localparam int StallLimit = 2000;

    typedef struct packed {
        logic signed [DataWidth-1:0] result;
        logic                        less;
        logic                        equal;
        logic                        greater;
        logic                        overflow;
        logic                        divide_by_zero;
    } alu_out_t;

    logic                        clk;
    logic                        rst_n;
    logic                        start;
    logic                        busy;
    logic [3:0]                  mode;
    logic signed [DataWidth-1:0] operand_a;
    logic signed [DataWidth-1:0] operand_b;
    logic                        done;
    logic signed [DataWidth-1:0] result;
    logic                        less;
    logic                        equal;
    logic                        greater;
    logic                        overflow;
    logic                        divide_by_zero;

    alu_out_t pending_q[$];
    int       error_count = 0;
    int       idle_cycles = 0;

    fixed_point_alu_core #(.FRAC_BITS(FracBits)) dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .mode(mode), .operand_a(operand_a), .operand_b(operand_b),
        .done(done), .result(result), .less(less), .equal(equal),
        .greater(greater), .overflow(overflow), .divide_by_zero(divide_by_zero)
    );

    always
    begin
        clk = 1'b1;
        #1;
        clk = 1'b0;
        #1;
    end

    // Clamp a wide value to the signed 32-bit range and flag any change.
    function automatic void saturate(input logic signed [127:0] v,
                                     output logic signed [DataWidth-1:0] r,
                                     output logic ovf);
        logic signed [127:0] hi;
        logic signed [127:0] lo;
        hi = 128'sd2147483647;
        lo = -128'sd2147483648;
        ovf = 1'b0;
        if (v > hi)
        begin
            r = hi[DataWidth-1:0];
            ovf = 1'b1;
        end
        else if (v < lo)
        begin
            r = lo[DataWidth-1:0];
            ovf = 1'b1;
        end
        else
            r = v[DataWidth-1:0];
    endfunction

    // Compute the expected output of one ALU operation.
    function automatic alu_out_t alu_predict(input logic [3:0] m,
                                             input logic signed [DataWidth-1:0] a,
                                             input logic signed [DataWidth-1:0] b);
        alu_out_t            o;
        logic signed [127:0] wa;
        logic signed [127:0] wb;
        logic signed [127:0] wide;
        logic [127:0]        ma;
        logic [127:0]        mb;
        logic [127:0]        mag;
        logic                neg;
        wa = a;
        wb = b;
        ma = (wa < 0) ? -wa : wa;
        mb = (wb < 0) ? -wb : wb;
        neg = (wa < 0) != (wb < 0);
        o = '0;
        o.less = a < b;
        o.equal = a == b;
        o.greater = a > b;
        case (m)
            OP_ADD: saturate(wa + wb, o.result, o.overflow);
            OP_SUB: saturate(wa - wb, o.result, o.overflow);
            OP_MUL:
            begin
                // round half away from zero on the magnitude
                mag = (ma * mb + (128'd1 << (FracBits - 1))) >> FracBits;
                wide = neg ? -$signed(mag) : $signed(mag);
                saturate(wide, o.result, o.overflow);
            end
            OP_DIV:
            begin
                if (b == 0)
                    o.divide_by_zero = 1'b1;
                else
                begin
                    mag = (2 * (ma << FracBits) + mb) / (2 * mb);
                    wide = neg ? -$signed(mag) : $signed(mag);
                    saturate(wide, o.result, o.overflow);
                end
            end
            OP_MIN: o.result = (a < b) ? a : b;
            OP_MAX: o.result = (a > b) ? a : b;
            OP_INC: saturate(wa + 1, o.result, o.overflow);
            OP_DEC: saturate(wa - 1, o.result, o.overflow);
            OP_I2F: saturate(wa * (128'sd1 <<< FracBits), o.result, o.overflow);
            OP_F2I: o.result = a >>> FracBits;
            default: o.result = '0;
        endcase
        return o;
    endfunction

    // Send one item: hold start until accepted, then drop it for an optional gap.
    task automatic send_item(input logic [3:0] m,
                             input logic signed [DataWidth-1:0] a,
                             input logic signed [DataWidth-1:0] b);
        int gap;
        start <= 1'b1;
        mode <= m;
        operand_a <= a;
        operand_b <= b;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        pending_q.push_back(alu_predict(m, a, b));
        // mostly back-to-back, sometimes a short gap, rarely a long one
        gap = $urandom_range(0, 99);
        if (gap < 60)
            gap = 0;
        else if (gap < 95)
            gap = $urandom_range(1, 4);
        else
            gap = $urandom_range(20, 80);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    function automatic logic signed [DataWidth-1:0] rand_word();
        int k;
        k = $urandom_range(0, 9);
        case (k)
            0: return 32'sh7fffffff;
            1: return 32'sh80000000;
            2: return 32'sd0;
            3: return $signed(32'($urandom_range(0, 1023))) - 512;
            4: return $signed(32'($urandom_range(0, 65535))) - 32768;
            5: return $signed($urandom) >>> $urandom_range(0, 24);
            default: return $signed($urandom);
        endcase
    endfunction

    task automatic test_directed();
        op_t op;
        op = op.first();
        // extremes and every operation
        for (int i = 0; i < 10; i++)
        begin
            send_item(op, 32'sh7fffffff, 32'sh7fffffff);
            op = op.next();
        end
        send_item(OP_ADD, 32'sh80000000, 32'sh80000000);
        send_item(OP_SUB, 32'sh80000000, 32'sh00000001);
        send_item(OP_MUL, 32'sh80000000, 32'sh80000000);
        send_item(OP_MUL, 32'sd384, 32'sd1);     // half rounds away from zero
        send_item(OP_MUL, -32'sd384, 32'sd1);
        send_item(OP_DIV, 32'sd100, 32'sd0);     // divide by zero
        send_item(OP_DIV, 32'sh80000000, 32'sd1);
        send_item(OP_DIV, -32'sd1, 32'sd2);
        send_item(OP_MIN, 32'sd5, 32'sd5);
        send_item(OP_MAX, -32'sd5, 32'sd7);
        send_item(OP_INC, 32'sh7fffffff, 32'sd0);
        send_item(OP_DEC, 32'sh80000000, 32'sd0);
        send_item(OP_I2F, 32'sh80000000, 32'sd0);
        send_item(OP_F2I, -32'sd1, 32'sd0);
        send_item(4'd15, 32'sd3, -32'sd3);       // unused mode
    endtask

    task automatic test_random(input int count);
        logic [3:0] m;
        for (int i = 0; i < count; i++)
        begin
            m = ($urandom_range(0, 19) == 0) ? 4'($urandom_range(10, 15))
                                             : 4'($urandom_range(0, 9));
            send_item(m, rand_word(), ($urandom_range(0, 7) == 0) ? rand_word()
                                                                 : $signed($urandom));
        end
    endtask

    // Hold the sender until every outstanding item has produced its result.
    task automatic drain_results();
        start <= 1'b0;
        while (pending_q.size() != 0)
            @(posedge clk);
    endtask

    // Check each strobed result against the oldest prediction.
    always @(posedge clk)
    begin
        alu_out_t exp_o;
        if (rst_n && done)
        begin
            if (pending_q.size() == 0)
            begin
                $error("result with no item outstanding: result=%0d", result);
                error_count++;
            end
            else
            begin
                exp_o = pending_q.pop_front();
                if (result !== exp_o.result)
                begin
                    $error("result: expected %0d actual %0d", exp_o.result, result);
                    error_count++;
                end
                if (less !== exp_o.less)
                begin
                    $error("less: expected %0b actual %0b", exp_o.less, less);
                    error_count++;
                end
                if (equal !== exp_o.equal)
                begin
                    $error("equal: expected %0b actual %0b", exp_o.equal, equal);
                    error_count++;
                end
                if (greater !== exp_o.greater)
                begin
                    $error("greater: expected %0b actual %0b", exp_o.greater, greater);
                    error_count++;
                end
                if (overflow !== exp_o.overflow)
                begin
                    $error("overflow: expected %0b actual %0b", exp_o.overflow, overflow);
                    error_count++;
                end
                if (divide_by_zero !== exp_o.divide_by_zero)
                begin
                    $error("divide_by_zero: expected %0b actual %0b",
                           exp_o.divide_by_zero, divide_by_zero);
                    error_count++;
                end
            end
        end
    end

    // Watchdog: count cycles with no accepted item and no result.
    always @(posedge clk)
    begin
        if ((start && !busy) || done)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= StallLimit)
        begin
            $display("== FAIL ==");
            $finish;
        end
    end

    initial
    begin
        rst_n = 1'b0;
        start = 1'b0;
        mode = '0;
        operand_a = '0;
        operand_b = '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        drain_results();
        test_random(600);
        drain_results();
        test_random(600);
        drain_results();
        repeat (Latency + 8) @(posedge clk);
        if (error_count == 0 && pending_q.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end
endmodule
